// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Expects i_clk and i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bba_pkg.sv
// Package for the buddy allocator: sequencer states, datapath ops,
// control/status structs, status codes and the order helper. No dependencies.
`default_nettype none

package bba_pkg;

    localparam int ORD_W = 4;
    localparam logic [13:0] MAX_PAGES = 14'h3F00;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_NOSPC  = 2'd1;
    localparam logic [1:0] STS_BADCNT = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_TO_RD,
        S_TO_EV,
        S_SPLIT_CHK,
        S_PUT,
        S_MG_CHK,
        S_MG_EV,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR,
        OP_LOAD,
        OP_DECODE,
        OP_TO_RD,
        OP_TO_EV,
        OP_SPLIT,
        OP_PUT,
        OP_MG_RD,
        OP_MG_TAKE,
        OP_FREE_SET,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic dec_fail;
        logic more;
        logic at_top;
        logic merge_ok;
        logic clr_done;
        logic out_free;
    } t_stat;

    // ceil(log2(ceil(pages/4))), valid for 1..MAX_PAGES
    function automatic logic [ORD_W-1:0] ceil_order(input logic [13:0] pages);
        logic [14:0] sum;
        logic [11:0] chunks;
        logic [11:0] cm1;
        logic [ORD_W-1:0] o;
        sum    = 15'(pages) + 15'd3;
        chunks = sum[13:2];
        cm1    = chunks - 12'd1;
        o      = '0;
        for (int i = 0; i < 12; i++) begin
            if (cm1[i]) begin
                o = ORD_W'(i + 1);
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bba_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/bba_ctrl.sv
// Sequencer of the buddy allocator: walks clear, decode, unlink, split,
// merge and insert steps. Depends on bba_pkg.
`default_nettype none

module bba_ctrl import bba_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_tvalid,
    output logic       o_s_tready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.dec_fail) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_TO_RD;
                    n_ret   = i_stat.kind ? S_MG_CHK : S_SPLIT_CHK;
                end
            end
            S_TO_RD: n_state = S_TO_EV;
            S_TO_EV: n_state = r_ret;
            S_SPLIT_CHK: begin
                if (i_stat.more) begin
                    n_state = S_TO_RD;
                    n_ret   = S_PUT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_PUT: n_state = i_stat.kind ? S_FINISH : S_SPLIT_CHK;
            S_MG_CHK: begin
                if (i_stat.at_top) begin
                    n_state = S_TO_RD;
                    n_ret   = S_PUT;
                end else begin
                    n_state = S_MG_EV;
                end
            end
            S_MG_EV: begin
                n_state = S_TO_RD;
                n_ret   = i_stat.merge_ok ? S_MG_CHK : S_PUT;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.op   = OP_NOP;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLEAR:  o_cmd.op = OP_CLR;
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) o_cmd.op = OP_LOAD;
            end
            S_DECODE: o_cmd.op = OP_DECODE;
            S_TO_RD:  o_cmd.op = OP_TO_RD;
            S_TO_EV:  o_cmd.op = OP_TO_EV;
            S_SPLIT_CHK: begin
                if (i_stat.more) o_cmd.op = OP_SPLIT;
            end
            S_PUT:    o_cmd.op = OP_PUT;
            S_MG_CHK: o_cmd.op = i_stat.at_top ? OP_FREE_SET : OP_MG_RD;
            S_MG_EV:  o_cmd.op = i_stat.merge_ok ? OP_MG_TAKE : OP_FREE_SET;
            S_FINISH: begin
                if (i_stat.out_free) o_cmd.op = OP_RESULT;
            end
            default:  o_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/bba_dp.sv
// Datapath of the buddy allocator: slot tables, list heads/tails, order
// logic and the result register. Depends on bba_pkg, bba_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bba_dp import bba_pkg::*; #(
    parameter int TABLE_ORDER = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic [23:0] i_s_tdata,
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata
);

    localparam int SW    = TABLE_ORDER;
    localparam int LW    = $clog2(TABLE_ORDER);
    localparam int SLOTS = 1 << TABLE_ORDER;
    localparam logic [4:0] TOP = 5'(TABLE_ORDER);

    // item registers
    logic             r_kind;
    logic [13:0]      r_pages;
    logic [SW-1:0]    r_ix;
    logic [SW-1:0]    r_cur;
    logic [ORD_W-1:0] r_ord;
    logic [ORD_W-1:0] r_k;
    logic [ORD_W-1:0] r_put_lv;
    logic [1:0]       r_status;
    logic [15:0]      r_out_data;
    // control registers
    logic             r_out_valid;
    logic [SW-1:0]    r_clr;
    logic [TABLE_ORDER-1:0] r_ne;
    // list ends
    logic [SW-1:0]    r_head [TABLE_ORDER];
    logic [SW-1:0]    r_tail [TABLE_ORDER];

    // slot table ports
    logic             info_we, next_we, prev_we;
    logic [SW-1:0]    info_wa, next_wa, prev_wa, rd_addr;
    logic [ORD_W:0]   info_wd, info_q;
    logic [SW-1:0]    next_wd, prev_wd, next_q, prev_q;

    logic             rd_free;
    logic [ORD_W-1:0] rd_lvl;
    logic             lvl_ok;

    logic [ORD_W-1:0] ord_c, scan_c;
    logic             bad_c, big_c, found_c;
    logic [1:0]       dec_status;
    logic [LW-1:0]    lst_idx;
    logic [SW-1:0]    head_q, tail_q;
    logic             ne_q;
    logic [SW-1:0]    bit_c, nx_c;
    logic             cur_head, cur_tail;
    logic [31:0]      ix_wide, gi_wide;

    assign rd_free = info_q[ORD_W];
    assign rd_lvl  = info_q[ORD_W-1:0];
    assign lvl_ok  = {1'b0, rd_lvl} < TOP;

    // request decode
    assign ord_c = ceil_order(r_pages);
    assign bad_c = (r_pages == 14'd0) || (r_pages > MAX_PAGES);
    assign big_c = {1'b0, ord_c} >= TOP;

    // lowest non-empty list at or above the requested order
    always_comb begin
        found_c = 1'b0;
        scan_c  = '0;
        for (int i = TABLE_ORDER - 1; i >= 0; i--) begin
            if (r_ne[i] && (5'(i) >= {1'b0, ord_c})) begin
                found_c = 1'b1;
                scan_c  = ORD_W'(i);
            end
        end
    end

    always_comb begin
        if (bad_c)       dec_status = STS_BADCNT;
        else if (r_kind) dec_status = big_c ? STS_BADCNT : STS_OK;
        else             dec_status = found_c ? STS_OK : STS_NOSPC;
    end

    // one list index per cycle
    always_comb begin
        case (i_cmd.op)
            OP_DECODE: lst_idx = scan_c[LW-1:0];
            OP_TO_EV:  lst_idx = rd_lvl[LW-1:0];
            default:   lst_idx = r_put_lv[LW-1:0];
        endcase
    end

    assign head_q   = r_head[lst_idx];
    assign tail_q   = r_tail[lst_idx];
    assign ne_q     = r_ne[lst_idx];
    assign cur_head = (head_q == r_cur);
    assign cur_tail = (tail_q == r_cur);

    assign bit_c   = SW'(1) << r_ord;
    assign nx_c    = r_ix ^ bit_c;
    assign rd_addr = (i_cmd.op == OP_MG_RD) ? nx_c : r_cur;

    assign ix_wide = 32'(i_s_tdata[23:14]);
    assign gi_wide = 32'(r_ix);

    // status to sequencer
    always_comb begin
        o_stat.kind     = r_kind;
        o_stat.dec_fail = dec_status != STS_OK;
        o_stat.more     = r_k > r_ord;
        o_stat.at_top   = ({1'b0, r_ord} + 5'd1) >= TOP;
        o_stat.merge_ok = rd_free && (rd_lvl == r_ord);
        o_stat.clr_done = &r_clr;
        o_stat.out_free = !r_out_valid || i_m_tready;
    end

    // table writes
    always_comb begin
        info_we = 1'b0;
        info_wa = r_cur;
        info_wd = '0;
        next_we = 1'b0;
        next_wa = prev_q;
        next_wd = next_q;
        prev_we = 1'b0;
        prev_wa = next_q;
        prev_wd = prev_q;
        case (i_cmd.op)
            OP_CLR: begin
                info_we = 1'b1;
                info_wa = r_clr;
            end
            OP_TO_EV: begin
                if (rd_free) begin
                    info_we = 1'b1;
                    info_wd = {1'b0, rd_lvl};
                    // middle of list: bridge neighbors
                    if (lvl_ok && !cur_head && !cur_tail) begin
                        next_we = 1'b1;
                        prev_we = 1'b1;
                    end
                end
            end
            OP_PUT: begin
                info_we = 1'b1;
                info_wd = {1'b1, r_put_lv};
                if (ne_q) begin
                    next_we = 1'b1;
                    next_wa = tail_q;
                    next_wd = r_cur;
                    prev_we = 1'b1;
                    prev_wa = r_cur;
                    prev_wd = tail_q;
                end
            end
            default: ;
        endcase
    end

    bba_ram #(.WIDTH(ORD_W + 1), .DEPTH(SLOTS)) u_info (
        .i_clk  (i_clk),
        .i_we   (info_we),
        .i_waddr(info_wa),
        .i_wdata(info_wd),
        .i_raddr(rd_addr),
        .o_rdata(info_q)
    );

    bba_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next (
        .i_clk  (i_clk),
        .i_we   (next_we),
        .i_waddr(next_wa),
        .i_wdata(next_wd),
        .i_raddr(rd_addr),
        .o_rdata(next_q)
    );

    bba_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_prev (
        .i_clk  (i_clk),
        .i_we   (prev_we),
        .i_waddr(prev_wa),
        .i_wdata(prev_wd),
        .i_raddr(rd_addr),
        .o_rdata(prev_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clr       <= '0;
            r_ne        <= '0;
        end else begin
            if (r_out_valid && i_m_tready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                OP_CLR:    r_clr <= r_clr + SW'(1);
                OP_TO_EV: begin
                    if (rd_free && lvl_ok && cur_head && cur_tail) r_ne[lst_idx] <= 1'b0;
                end
                OP_PUT:    r_ne[lst_idx] <= 1'b1;
                OP_RESULT: r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_kind  <= i_s_tuser;
                r_pages <= i_s_tdata[13:0];
                r_ix    <= ix_wide[SW-1:0];
            end
            OP_DECODE: begin
                r_ord    <= ord_c;
                r_k      <= scan_c;
                r_status <= dec_status;
                if (!r_kind) begin
                    r_ix  <= head_q;
                    r_cur <= head_q;
                end else begin
                    r_cur <= r_ix;
                end
            end
            OP_TO_EV: begin
                if (rd_free && lvl_ok && !(cur_head && cur_tail)) begin
                    if (cur_head)      r_head[lst_idx] <= next_q;
                    else if (cur_tail) r_tail[lst_idx] <= prev_q;
                end
            end
            OP_SPLIT: begin
                r_cur    <= r_ix + (SW'(1) << (r_k - ORD_W'(1)));
                r_put_lv <= r_k - ORD_W'(1);
                r_k      <= r_k - ORD_W'(1);
            end
            OP_PUT: begin
                if (!ne_q) r_head[lst_idx] <= r_cur;
                r_tail[lst_idx] <= r_cur;
            end
            OP_MG_TAKE: begin
                r_cur <= nx_c;
                r_ix  <= r_ix & ~bit_c;
                r_ord <= r_ord + ORD_W'(1);
            end
            OP_FREE_SET: begin
                r_cur    <= r_ix;
                r_put_lv <= r_ord;
            end
            OP_RESULT: begin
                if (r_status == STS_OK) r_out_data <= {r_ord, gi_wide[9:0], r_status};
                else                    r_out_data <= {14'd0, r_status};
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `ASSERT_IMP(a_fail_zero, r_out_valid && (r_out_data[1:0] != STS_OK), r_out_data[15:2] == 14'd0, "failed result carries index or order")
    `ASSERT_IMP(a_status_code, r_out_valid, (r_out_data[1:0] == STS_OK) || (r_out_data[1:0] == STS_NOSPC) || (r_out_data[1:0] == STS_BADCNT), "undefined status code")
    `ASSERT_IMP(a_result_room, i_cmd.op == OP_RESULT, !r_out_valid || i_m_tready, "result overwrites an untaken item")

endmodule

`default_nettype wire

// File: rtl/buddy_block_allocator.sv
// Top level of the binary buddy block allocator.
// Depends on bba_pkg, bba_ctrl, bba_dp (which holds bba_ram instances).
//
// Usage:
//  Slave channel takes one request item: tuser = kind (0 alloc, 1 free),
//  tdata = page_count and block_index. Master channel returns one result
//  item per request: status, granted_index, granted_order.
//  Requests are worked one at a time by a sequencer over three slot tables
//  (free/level, next link, prev link), each a RAM with one read and one
//  write port; an unlink or a buddy check is a read step and then an
//  evaluate step. A request that fails decode goes straight to its result;
//  an alloc unlinks the found block, then splits it, inserting each upper
//  half; a free merges with its free buddy level by level, then inserts
//  the merged block. The result item is registered in its finish step.
//  After reset every entry of the free/level table is swept to zero, with
//  tready low; list state resets at once.
//  The result sits in an output register: the next request is taken while
//  it waits, and the sequencer only stalls at the end of that next request
//  if the receiver still holds tready low.
`default_nettype none

module buddy_block_allocator import bba_pkg::*; #(
    parameter int TABLE_ORDER = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // [13:0] page_count, [23:14] block_index
    input  wire logic        i_s_tuser,  // [0] kind
    // result channel
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata   // [1:0] status, [11:2] granted_index,
                                         // [15:12] granted_order
);

    t_cmd  cmd;
    t_stat stat;

    bba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    bba_dp #(.TABLE_ORDER(TABLE_ORDER)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

endmodule

`default_nettype wire
